### hdl/terminal_escape_key_decoder_defines.svh
// Assertion macros used by the checker file.
`ifndef TERMINAL_ESCAPE_KEY_DECODER_DEFINES_SVH
`define TERMINAL_ESCAPE_KEY_DECODER_DEFINES_SVH

// Check a property outside reset.
`define TEKD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Check a property at every edge, reset included.
`define TEKD_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hdl/tekd_pkg.sv
`timescale 1ns / 1ps

package tekd_pkg;

	localparam logic [7:0] CH_ESC   = 8'h1b;
	localparam logic [7:0] CH_LBR   = 8'h5b;
	localparam logic [7:0] CH_TILDE = 8'h7e;
	localparam logic [7:0] CH_SEMI  = 8'h3b;
	localparam logic [7:0] CH_O     = 8'h4f;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_ONE   = 8'h31;
	localparam logic [7:0] CH_TWO   = 8'h32;
	localparam logic [7:0] CH_THREE = 8'h33;
	localparam logic [7:0] CH_FOUR  = 8'h34;
	localparam logic [7:0] CH_FIVE  = 8'h35;
	localparam logic [7:0] CH_SIX   = 8'h36;
	localparam logic [7:0] CH_SEVEN = 8'h37;
	localparam logic [7:0] CH_EIGHT = 8'h38;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_B     = 8'h42;
	localparam logic [7:0] CH_C     = 8'h43;
	localparam logic [7:0] CH_D     = 8'h44;
	localparam logic [7:0] CH_F     = 8'h46;
	localparam logic [7:0] CH_H     = 8'h48;

	localparam logic [8:0] K_NONE   = 9'd0;
	localparam logic [8:0] K_LEFT   = 9'd256;
	localparam logic [8:0] K_RIGHT  = 9'd257;
	localparam logic [8:0] K_UP     = 9'd258;
	localparam logic [8:0] K_DOWN   = 9'd259;
	localparam logic [8:0] K_DEL    = 9'd260;
	localparam logic [8:0] K_HOME   = 9'd261;
	localparam logic [8:0] K_END    = 9'd262;
	localparam logic [8:0] K_PGUP   = 9'd263;
	localparam logic [8:0] K_PGDN   = 9'd264;
	localparam logic [8:0] K_PSTART = 9'd265;
	localparam logic [8:0] K_PEND   = 9'd266;
	localparam logic [8:0] K_MAX    = K_PEND;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'd0,
		ST_ESC    = 4'd1,
		ST_SEQ0   = 4'd2,
		ST_DIGIT  = 4'd3,
		ST_SEMI1  = 4'd4,
		ST_SEMI2  = 4'd5,
		ST_PASTE1 = 4'd6,
		ST_PASTE2 = 4'd7
	} parse_state_t;

	typedef struct packed {
		parse_state_t state;
		logic [7:0]   held;
		logic         emit;
		logic [8:0]   key;
	} step_t;

	// Final letter of a CSI sequence, K_NONE when unmatched.
	function automatic logic [8:0] letter_key(input logic [7:0] b);
		logic [8:0] k;
		case (b)
			CH_A:    k = K_UP;
			CH_B:    k = K_DOWN;
			CH_C:    k = K_RIGHT;
			CH_D:    k = K_LEFT;
			CH_H:    k = K_HOME;
			CH_F:    k = K_END;
			default: k = K_NONE;
		endcase
		return k;
	endfunction

	// Digit ahead of a tilde, K_NONE when unmatched.
	function automatic logic [8:0] tilde_key(input logic [7:0] d);
		logic [8:0] k;
		case (d)
			CH_ONE:   k = K_HOME;
			CH_THREE: k = K_DEL;
			CH_FOUR:  k = K_END;
			CH_FIVE:  k = K_PGUP;
			CH_SIX:   k = K_PGDN;
			CH_SEVEN: k = K_HOME;
			CH_EIGHT: k = K_END;
			default:  k = K_NONE;
		endcase
		return k;
	endfunction

endpackage

### hdl/tekd_step.sv
`timescale 1ns / 1ps

module tekd_step import tekd_pkg::*; (
	input  parse_state_t state,
	input  logic [7:0]   held,
	input  logic [7:0]   in_byte,
	input  logic         timeout,
	output step_t        step
);

	logic       fin;
	logic [8:0] k;

	always_comb begin
		step.state = ST_IDLE;
		step.held  = held;
		step.emit  = 1'b0;
		step.key   = K_NONE;
		fin = 1'b0;
		k   = K_NONE;

		if (state == ST_IDLE || state > ST_PASTE2) begin
			if (!timeout) begin
				if (in_byte == CH_ESC) begin
					step.state = ST_ESC;
				end else begin
					step.emit = 1'b1;
					step.key  = {1'b0, in_byte};
				end
			end
		end else if (timeout) begin
			step.emit = 1'b1;
			step.key  = {1'b0, CH_ESC};
		end else begin
			case (state)
				ST_ESC: begin
					step.held  = in_byte;
					step.state = ST_SEQ0;
				end
				ST_SEQ0: begin
					if (held == CH_LBR && in_byte inside {[CH_ZERO:CH_NINE]}) begin
						step.held  = in_byte;
						step.state = ST_DIGIT;
					end else begin
						fin = 1'b1;
						if (held == CH_LBR) begin
							k = letter_key(in_byte);
						end else if (held == CH_O) begin
							if (in_byte == CH_H) begin
								k = K_HOME;
							end else if (in_byte == CH_F) begin
								k = K_END;
							end
						end
					end
				end
				ST_DIGIT: begin
					if (in_byte == CH_SEMI) begin
						step.state = ST_SEMI1;
					end else if (in_byte != CH_TILDE && held == CH_TWO && in_byte == CH_ZERO) begin
						step.state = ST_PASTE1;
					end else begin
						fin = 1'b1;
						if (in_byte == CH_TILDE) begin
							k = tilde_key(held);
						end
					end
				end
				ST_SEMI1: begin
					step.state = ST_SEMI2;
				end
				ST_SEMI2: begin
					fin = 1'b1;
					k   = letter_key(in_byte);
				end
				ST_PASTE1: begin
					step.held  = in_byte;
					step.state = ST_PASTE2;
				end
				default: begin
					fin = 1'b1;
					if (in_byte == CH_TILDE) begin
						if (held == CH_ZERO) begin
							k = K_PSTART;
						end else if (held == CH_ONE) begin
							k = K_PEND;
						end
					end
				end
			endcase
			if (fin) begin
				step.emit = 1'b1;
				step.key  = (k != K_NONE) ? k : {1'b0, CH_ESC};
			end
		end
	end

endmodule

### hdl/terminal_escape_key_decoder.sv
`timescale 1ns / 1ps
// A key is offered on key_valid from the result register; its byte passes through the request register first.
// Throughput: one request per cycle while key_stall does not hold back the result register; the parse FSM
// decides each byte combinationally and its state register feeds straight back into the next decision.
// Reset (arst_n low, asynchronous): parse state idle, held byte zero, both
// pipeline stages empty.

module terminal_escape_key_decoder import tekd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic [7:0] in_byte,
	input  logic       timeout,
	output logic       key_valid,
	input  logic       key_stall,
	output logic [8:0] key_code
);

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         timeout_s1;
	parse_state_t state_q;
	logic [7:0]   held_q;
	logic         key_valid_q;
	logic [8:0]   key_q;
	logic         advance;
	step_t        step;

	tekd_step u_step (
		.state   (state_q),
		.held    (held_q),
		.in_byte (byte_s1),
		.timeout (timeout_s1),
		.step    (step)
	);

	// Process the held request once the result register can take its key.
	assign advance   = valid_s1 && (!key_valid_q || !key_stall);
	assign req_stall = valid_s1 && !advance;
	assign key_valid = key_valid_q;
	assign key_code  = key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			byte_s1    <= in_byte;
			timeout_s1 <= timeout;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			held_q  <= 8'h00;
		end else if (advance) begin
			state_q <= step.state;
			held_q  <= step.held;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_valid_q <= 1'b0;
		end else if (advance && step.emit) begin
			key_valid_q <= 1'b1;
		end else if (!key_stall) begin
			key_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step.emit) begin
			key_q <= step.key;
		end
	end

endmodule

### hdl/tekd_checker.sv
`timescale 1ns / 1ps
`include "terminal_escape_key_decoder_defines.svh"

module tekd_checker import tekd_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_stall,
	input logic [7:0] in_byte,
	input logic       timeout,
	input logic       key_valid,
	input logic       key_stall,
	input logic [8:0] key_code
);

	// Hold a stalled key.
	`TEKD_ASSERT(a_key_hold, key_valid && key_stall |=> key_valid && $stable(key_code), "stalled key changed")
	// Hold a stalled request.
	`TEKD_ASSERT(a_req_hold, req_valid && req_stall |=> req_valid && $stable({timeout, in_byte}), "stalled request changed")
	// Only the known key codes come out.
	`TEKD_ASSERT(a_key_range, key_valid |-> key_code <= K_MAX, "key code out of range")
	// Requests back up only behind a blocked key.
	`TEKD_ASSERT(a_stall_cause, req_stall |-> key_valid && key_stall, "request stalled without cause")
	// Clear the output side once reset has been seen at an edge.
	`TEKD_ASSERT_ALWAYS(a_reset_empty, !arst_n |=> !key_valid && !req_stall, "output busy in reset")

endmodule

bind terminal_escape_key_decoder tekd_checker u_tekd_checker (.*);

### test/tb_terminal_escape_key_decoder.sv
`timescale 1ns / 1ps

module tb_terminal_escape_key_decoder;
	import tekd_pkg::*;

	// Item word: {timeout, byte}. A timeout item still carries a byte the block must ignore.
	localparam logic [8:0] TMO_ITEM = 9'h1ff;
	localparam int N_ITEMS = 1150;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       req_valid = 1'b0;
	logic       req_stall;
	logic [7:0] in_byte = 8'h00;
	logic       timeout = 1'b0;
	logic       key_valid;
	logic       key_stall = 1'b0;
	logic [8:0] key_code;

	class key_scoreboard;
		parse_state_t state;
		logic [7:0]   held;
		logic [8:0]   expected_keys[$];
		int errors, n_reqs, n_used, n_keys, n_seq_keys, n_timeouts;

		function new();
			state = ST_IDLE;
			held = 8'h00;
		endfunction

		function logic [8:0] csi_letter(input logic [7:0] c);
			case (c)
				CH_A: return K_UP;
				CH_B: return K_DOWN;
				CH_C: return K_RIGHT;
				CH_D: return K_LEFT;
				CH_H: return K_HOME;
				CH_F: return K_END;
				default: return K_NONE;
			endcase
		endfunction

		function logic [8:0] tilde_digit(input logic [7:0] d);
			case (d)
				CH_ONE, CH_SEVEN: return K_HOME;
				CH_THREE: return K_DEL;
				CH_FOUR, CH_EIGHT: return K_END;
				CH_FIVE: return K_PGUP;
				CH_SIX: return K_PGDN;
				default: return K_NONE;
			endcase
		endfunction

		// Advance the parse state by one accepted request and queue any key it yields.
		function void note_req(input logic [7:0] b, input logic t);
			logic       emit;
			logic [8:0] k;
			emit = 1'b1;
			k = K_NONE;
			n_reqs++;
			if (t)
				n_timeouts++;
			if (!(t && state == ST_IDLE))
				n_used++;
			if (state == ST_IDLE) begin
				if (t) begin
					emit = 1'b0;
				end else if (b == CH_ESC) begin
					state = ST_ESC;
					emit = 1'b0;
				end else begin
					k = {1'b0, b};
				end
			end else if (t) begin
				state = ST_IDLE;
				k = {1'b0, CH_ESC};
			end else begin
				case (state)
					ST_ESC: begin
						held = b;
						state = ST_SEQ0;
						emit = 1'b0;
					end
					ST_SEQ0: begin
						if (held == CH_LBR) begin
							if (b >= CH_ZERO && b <= CH_NINE) begin
								held = b;
								state = ST_DIGIT;
								emit = 1'b0;
							end else begin
								k = csi_letter(b);
							end
						end else if (held == CH_O) begin
							if (b == CH_H)
								k = K_HOME;
							else if (b == CH_F)
								k = K_END;
						end
					end
					ST_DIGIT: begin
						if (b == CH_TILDE) begin
							k = tilde_digit(held);
						end else if (b == CH_SEMI) begin
							state = ST_SEMI1;
							emit = 1'b0;
						end else if (held == CH_TWO && b == CH_ZERO) begin
							state = ST_PASTE1;
							emit = 1'b0;
						end
					end
					ST_SEMI1: begin
						state = ST_SEMI2;
						emit = 1'b0;
					end
					ST_SEMI2: begin
						k = csi_letter(b);
					end
					ST_PASTE1: begin
						held = b;
						state = ST_PASTE2;
						emit = 1'b0;
					end
					default: begin
						if (b == CH_TILDE) begin
							if (held == CH_ZERO)
								k = K_PSTART;
							else if (held == CH_ONE)
								k = K_PEND;
						end
					end
				endcase
				if (emit) begin
					state = ST_IDLE;
					if (k == K_NONE)
						k = {1'b0, CH_ESC};
				end
			end
			if (emit)
				expected_keys.push_back(k);
		endfunction

		function void check_key(input logic [8:0] k);
			logic [8:0] want;
			if (expected_keys.size() == 0) begin
				$display("%0t: unexpected key_code %0d, expected none", $time, k);
				errors++;
				return;
			end
			want = expected_keys.pop_front();
			n_keys++;
			if (want > 9'd255)
				n_seq_keys++;
			if (k !== want) begin
				$display("%0t: key_code mismatch, expected %0d, got %0d", $time, want, k);
				errors++;
			end
		endfunction
	endclass

	key_scoreboard sb = new();

	logic [8:0] stim[$];
	int burst_left = 0;
	int stall_left = 0;
	int stall_mode = 0;
	int stall_phase = 0;

	terminal_escape_key_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.in_byte(in_byte),
		.timeout(timeout),
		.key_valid(key_valid),
		.key_stall(key_stall),
		.key_code(key_code)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				sb.note_req(in_byte, timeout);
			if (key_valid && !key_stall)
				sb.check_key(key_code);
		end
	end

	// Receiver: switch between free flow, light, heavy and periodic stalling.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(5, 60);
		end else begin
			stall_left--;
		end
		stall_phase++;
		case (stall_mode)
			0: key_stall <= 1'b0;
			1: key_stall <= ($urandom_range(0, 3) == 0);
			2: key_stall <= ($urandom_range(0, 1) == 0);
			default: key_stall <= ((stall_phase % 7) < 3);
		endcase
	end

	function automatic logic [8:0] ch(input logic [7:0] c);
		return {1'b0, c};
	endfunction

	// Drive every queued request; hold each one until accepted, sometimes idle between bursts.
	task automatic send_stream();
		int gap;
		foreach (stim[i]) begin
			req_valid <= 1'b1;
			timeout <= stim[i][8];
			in_byte <= stim[i][7:0];
			do @(posedge clk); while (req_stall);
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				if (gap > 0) begin
					req_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end else begin
				burst_left--;
			end
		end
		stim.delete();
	endtask

	initial begin
		#5ms;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		logic [7:0] letters[6];
		logic [7:0] pick;
		int kind, pos, wd;
		letters = '{CH_A, CH_B, CH_C, CH_D, CH_H, CH_F};

		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		// Plain bytes, idle timeout, one of each sequence form, and broken sequences.
		stim = '{ch(8'h00), ch(8'hff), ch(8'h41), TMO_ITEM,
			ch(CH_ESC), ch(CH_LBR), ch(CH_A),
			ch(CH_ESC), ch(CH_O), ch(CH_F),
			ch(CH_ESC), ch(CH_LBR), ch(CH_FIVE), ch(CH_TILDE),
			ch(CH_ESC), ch(CH_LBR), ch(CH_ONE), ch(CH_SEMI), ch(CH_FIVE), ch(CH_D),
			ch(CH_ESC), ch(CH_LBR), ch(CH_TWO), ch(CH_ZERO), ch(CH_ZERO), ch(CH_TILDE),
			ch(CH_ESC), ch(CH_LBR), ch(CH_TWO), ch(CH_ZERO), ch(CH_ONE), ch(CH_TILDE),
			ch(CH_ESC), TMO_ITEM,
			ch(CH_ESC), ch(CH_LBR), ch(CH_NINE), ch(CH_TILDE),
			ch(CH_ESC), ch(8'h58), ch(8'h59)};
		send_stream();

		while (sb.n_used < N_ITEMS) begin
			kind = $urandom_range(0, 9);
			pick = ($urandom_range(0, 4) == 0) ? 8'($urandom) : letters[$urandom_range(0, 5)];
			case (kind)
				0, 1: stim.push_back({1'b0, 8'($urandom)});
				2: stim = '{ch(CH_ESC), ch(CH_LBR), ch(pick)};
				3: stim = '{ch(CH_ESC), ch(CH_O),
					ch(($urandom_range(0, 3) == 0) ? 8'($urandom)
						: ($urandom_range(0, 1) ? CH_H : CH_F))};
				4, 5: stim = '{ch(CH_ESC), ch(CH_LBR), ch(CH_ZERO + 8'($urandom_range(0, 9))),
					ch(($urandom_range(0, 6) == 0) ? 8'($urandom) : CH_TILDE)};
				6: stim = '{ch(CH_ESC), ch(CH_LBR), ch(CH_ZERO + 8'($urandom_range(0, 9))),
					ch(CH_SEMI), ch(8'($urandom)), ch(pick)};
				7: stim = '{ch(CH_ESC), ch(CH_LBR), ch(CH_TWO), ch(CH_ZERO),
					ch(($urandom_range(0, 4) == 0) ? 8'($urandom)
						: ($urandom_range(0, 1) ? CH_ONE : CH_ZERO)),
					ch(($urandom_range(0, 5) == 0) ? 8'($urandom) : CH_TILDE)};
				8: stim.push_back({1'b1, 8'($urandom)});
				default: begin
					stim.push_back(ch(CH_ESC));
					repeat ($urandom_range(1, 3))
						stim.push_back({($urandom_range(0, 9) == 0), 8'($urandom)});
				end
			endcase
			// Cut some sequences short with a timeout.
			if (stim.size() > 1 && $urandom_range(0, 7) == 0) begin
				pos = $urandom_range(1, stim.size() - 1);
				while (stim.size() > pos)
					void'(stim.pop_back());
				stim.push_back({1'b1, 8'($urandom)});
			end
			send_stream();
		end

		req_valid <= 1'b0;
		wd = 0;
		while (sb.expected_keys.size() > 0 && wd < 5000) begin
			@(posedge clk);
			wd++;
		end
		repeat (10) @(posedge clk);
		if (sb.expected_keys.size() > 0) begin
			$display("%0t: %0d key codes never arrived", $time, sb.expected_keys.size());
			sb.errors++;
		end

		$display("Decoded %0d keys (%0d from escape sequences) over %0d requests,",
			sb.n_keys, sb.n_seq_keys, sb.n_reqs);
		$display("with %0d timeouts and random stalls on both channels.", sb.n_timeouts);
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
